### rtl/displacement_warp_bilinear_defines.svh
// Assertion macros shared by the checker of displacement_warp_bilinear.
// No dependencies; expects clk_i and rst_ni in the including scope.
`ifndef DISPLACEMENT_WARP_BILINEAR_DEFINES_SVH
`define DISPLACEMENT_WARP_BILINEAR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DWB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DWB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/dwb_pkg.sv
// Shared types and constants for the displacement warp block.
// No dependencies.
package dwb_pkg;

  localparam int DEF_IMAGE_WIDTH  = 320;
  localparam int DEF_IMAGE_HEIGHT = 200;

  // Coordinate compare width: covers image sizes up to 8192.
  localparam int CMP_W = 13;
  // Blend sum: 255 * 64 fits in 14 bits.
  localparam int ACC_W = 14;
  localparam int WGT_W = 7;
  localparam logic [WGT_W-1:0] WGT_FULL = 7'd64;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  typedef logic [1:0] tap_t;
  localparam tap_t TAP_00 = 2'd0;
  localparam tap_t TAP_01 = 2'd1;
  localparam tap_t TAP_10 = 2'd2;
  localparam tap_t TAP_11 = 2'd3;

  typedef struct packed {
    logic wr;     // write item accepted this cycle
    logic load;   // render item accepted this cycle
    logic calc;   // compute position, weights, base address
    logic issue;  // issue one texel read
    tap_t tap;    // which texel of the 2x2 block
  } cmd_t;

  typedef struct packed {
    logic valid;     // displaced texel block lies inside the image
    logic bilinear;  // mode latched with the item
  } status_t;

endpackage

### rtl/dwb_ram.sv
// Generic single-clock RAM: one write port, one registered read port.
// No dependencies.
module dwb_ram #(
  parameter int Width = 8,
  parameter int Depth = 64000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/dwb_ctrl.sv
// Sequencer for the displacement warp: accepts items, steps texel reads.
// Depends on dwb_pkg.
module dwb_ctrl import dwb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  logic    operation_i,
  input  status_t status_i,
  output logic    busy,
  output logic    done_o,
  output cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CALC  = 5'b00010,
    S_ISSUE = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  tap_t   tap_q, tap_d;
  tap_t   tap_last;
  logic   accept;

  assign busy     = !(state_q == S_IDLE || state_q == S_DONE);
  assign done_o   = (state_q == S_DONE);
  assign accept   = start && !busy;
  assign tap_last = status_i.bilinear ? TAP_11 : TAP_00;

  always_comb begin
    state_d = state_q;
    tap_d   = tap_q;
    case (state_q)
      S_IDLE, S_DONE: begin
        if (accept && operation_i == OP_RENDER) begin
          state_d = S_CALC;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_CALC: begin
        tap_d   = TAP_00;
        state_d = S_ISSUE;
      end
      S_ISSUE: begin
        if (!status_i.valid) begin
          state_d = S_DONE;  // black pixel, nothing to read
        end else if (tap_q == tap_last) begin
          state_d = S_DRAIN;
        end else begin
          tap_d = tap_q + 2'd1;
        end
      end
      S_DRAIN: state_d = S_DONE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.wr    = accept && (operation_i == OP_WRITE);
    cmd_o.load  = accept && (operation_i == OP_RENDER);
    cmd_o.calc  = (state_q == S_CALC);
    cmd_o.issue = (state_q == S_ISSUE) && status_i.valid;
    cmd_o.tap   = tap_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tap_q   <= TAP_00;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
    end
  end

endmodule

### rtl/dwb_dp.sv
// Datapath of the displacement warp: address math, weights, image RAM, blend.
// Depends on dwb_pkg and dwb_ram.
module dwb_dp import dwb_pkg::*; #(
  parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic              bilinear_enable_i,
  input  logic [15:0]       texel_address_i,
  input  logic [7:0]        texel_value_i,
  input  logic [8:0]        pixel_x_i,
  input  logic [7:0]        pixel_y_i,
  input  logic signed [7:0] disp_x_i,
  input  logic signed [7:0] disp_y_i,
  output status_t           status_o,
  output logic [7:0]        pixel_value_o
);

  localparam int Depth = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int AddrW = $clog2(Depth);

  // item capture
  logic [8:0]        px_q;
  logic [7:0]        py_q;
  logic signed [7:0] dsx_q, dsy_q;
  logic              bil_q;

  logic [10:0]       dx, dy;
  logic              valid_d, valid_q;
  logic [AddrW-1:0]  base_d, base_q;
  logic [3:0]        wx0, wx1, wy0, wy1;
  logic [WGT_W-1:0]  w_d [4];
  logic [WGT_W-1:0]  w_q [4];

  logic [AddrW-1:0]  rd_addr, rd_off;
  logic [7:0]        rdata;
  logic              wr_en;
  logic              acc_en_q;
  tap_t              tap_q;
  logic [ACC_W-1:0]  acc_d, acc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q  <= pixel_x_i;
      py_q  <= pixel_y_i;
      dsx_q <= disp_x_i;
      dsy_q <= disp_y_i;
      bil_q <= bilinear_enable_i;
    end
  end

  // Integer part is the floor: sign-extended upper five bits.
  assign dx = {2'b00, px_q} + {{6{dsx_q[7]}}, dsx_q[7:3]};
  assign dy = {3'b000, py_q} + {{6{dsy_q[7]}}, dsy_q[7:3]};

  assign valid_d = !dx[10] && !dy[10]
                   && (CMP_W'(dx[9:0]) < CMP_W'(IMAGE_WIDTH - 1))
                   && (CMP_W'(dy[9:0]) < CMP_W'(IMAGE_HEIGHT - 1));

  assign base_d = AddrW'(32'(dy[9:0]) * 32'(IMAGE_WIDTH) + 32'(dx[9:0]));

  assign wx1 = {1'b0, dsx_q[2:0]};
  assign wy1 = {1'b0, dsy_q[2:0]};
  assign wx0 = 4'd8 - wx1;
  assign wy0 = 4'd8 - wy1;

  always_comb begin
    if (bil_q) begin
      w_d[TAP_00] = {3'b000, wx0} * {3'b000, wy0};
      w_d[TAP_01] = {3'b000, wx1} * {3'b000, wy0};
      w_d[TAP_10] = {3'b000, wx0} * {3'b000, wy1};
      w_d[TAP_11] = {3'b000, wx1} * {3'b000, wy1};
    end else begin
      // nearest: full weight on the base texel, sum >> 6 returns it unchanged
      w_d[TAP_00] = WGT_FULL;
      w_d[TAP_01] = '0;
      w_d[TAP_10] = '0;
      w_d[TAP_11] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      valid_q <= valid_d;
      base_q  <= base_d;
      w_q     <= w_d;
    end
  end

  always_comb begin
    case (cmd_i.tap)
      TAP_00:  rd_off = '0;
      TAP_01:  rd_off = AddrW'(1);
      TAP_10:  rd_off = AddrW'(IMAGE_WIDTH);
      TAP_11:  rd_off = AddrW'(IMAGE_WIDTH + 1);
      default: rd_off = '0;
    endcase
  end

  assign rd_addr = base_q + rd_off;
  assign wr_en   = cmd_i.wr && (32'(texel_address_i) < 32'(Depth));

  dwb_ram #(
    .Width (8),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (AddrW'(texel_address_i)),
    .wdata_i (texel_value_i),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // RAM read data is registered: it arrives in the cycle after issue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_en_q <= 1'b0;
    end else begin
      acc_en_q <= cmd_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    tap_q <= cmd_i.tap;
  end

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.calc) begin
      acc_d = '0;
    end else if (acc_en_q) begin
      acc_d = acc_q + ACC_W'(rdata) * ACC_W'(w_q[tap_q]);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign status_o.valid    = valid_q;
  assign status_o.bilinear = bil_q;
  assign pixel_value_o     = acc_q[ACC_W-1:6];

endmodule

### rtl/displacement_warp_bilinear.sv
// Displacement warp with bilinear option. A write item never makes the block busy.
// A render item shows its pixel on done_o once its texel reads are through, and the
// next item is taken in that same done cycle. It reads 4 texels in bilinear mode,
// 1 in nearest mode and none for a black pixel, in turn through the single read
// port of the image RAM. Reset clears the sequencer and the mode register; image
// contents are undefined until written, no clearing pass.
module displacement_warp_bilinear import dwb_pkg::*; #(
  parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // item handshake
  input  logic              start,
  output logic              busy,
  // item payload
  input  logic              operation_i,
  input  logic [15:0]       texel_address_i,
  input  logic [7:0]        texel_value_i,
  input  logic [8:0]        pixel_x_i,
  input  logic [7:0]        pixel_y_i,
  input  logic signed [7:0] disp_x_i,
  input  logic signed [7:0] disp_y_i,
  // result: valid for exactly one cycle while done_o is high
  output logic              done_o,
  output logic [7:0]        pixel_value_o,
  // mode register write
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i
);

  // Mode register: 0 = nearest texel, 1 = bilinear blend.
  logic bilinear_enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bilinear_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      bilinear_enable_q <= cfg_wdata_i;
    end
  end

  cmd_t    cmd;
  status_t status;

  // Sequencer: idle -> calc -> issue reads (one per texel) -> drain -> done.
  // Black pixels skip the reads and the drain: the accumulator is already zero.
  dwb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .operation_i (operation_i),
    .status_i    (status),
    .busy        (busy),
    .done_o      (done_o),
    .cmd_o       (cmd)
  );

  // Datapath: position + floor(disp), bounds test, base address, weights,
  // image RAM and multiply-accumulate. Writes go straight to the RAM in the
  // accept cycle.
  dwb_dp #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .bilinear_enable_i (bilinear_enable_q),
    .texel_address_i   (texel_address_i),
    .texel_value_i     (texel_value_i),
    .pixel_x_i         (pixel_x_i),
    .pixel_y_i         (pixel_y_i),
    .disp_x_i          (disp_x_i),
    .disp_y_i          (disp_y_i),
    .status_o          (status),
    .pixel_value_o     (pixel_value_o)
  );

endmodule

### rtl/dwb_checker.sv
// Port-level checks for displacement_warp_bilinear, bound to the top level.
// Depends on displacement_warp_bilinear_defines.svh.
`include "displacement_warp_bilinear_defines.svh"

module dwb_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic operation_i,
  input logic done_o
);

  // an accepted render makes the block busy
  `DWB_ASSERT_NEXT(a_render_busy, start && !busy && operation_i, busy, "render not busy")
  // a write produces no result and frees the block at once
  `DWB_ASSERT_NEXT(a_write_quiet, start && !busy && !operation_i, !busy && !done_o, "write stalled")
  // the result cycle is also an accept cycle
  `DWB_ASSERT_NOW(a_done_ready, done_o, !busy, "busy during result")
  // results never come in consecutive cycles
  `DWB_ASSERT_NEXT(a_done_single, done_o, !done_o, "double result")

endmodule

bind displacement_warp_bilinear dwb_checker u_dwb_checker (.*);

### verif/dwb_tb_pkg.sv
// Scoreboard for the displacement warp testbench: mirrors the image store and
// the filter mode, predicts each rendered pixel and checks it in order.
// Depends on dwb_pkg for image size and operation codes.
package dwb_tb_pkg;
  import dwb_pkg::*;

  localparam int IMG_W    = DEF_IMAGE_WIDTH;
  localparam int IMG_H    = DEF_IMAGE_HEIGHT;
  localparam int NTEXELS  = IMG_W * IMG_H;

  class warp_scoreboard;
    logic [7:0] texels [NTEXELS];
    logic       bilinear;
    logic [7:0] pending_pixels [$];
    int         errors;

    function new();
      bilinear = 1'b0;
      errors   = 0;
    endfunction

    function void set_mode(logic b);
      bilinear = b;
    endfunction

    // Expected pixel for one render item under the current mode.
    function logic [7:0] warp_pixel(logic [8:0] px, logic [7:0] py,
                                    logic signed [7:0] dx, logic signed [7:0] dy);
      int col, row, fx, fy, base, sum;
      col = int'(px) + int'(dx >>> 3);
      row = int'(py) + int'(dy >>> 3);
      fx  = int'(dx[2:0]);
      fy  = int'(dy[2:0]);
      // texel plus its right and lower neighbours must fit
      if (col < 0 || col >= IMG_W - 1 || row < 0 || row >= IMG_H - 1)
        return 8'd0;
      base = row * IMG_W + col;
      if (!bilinear)
        return texels[base];
      sum = int'(texels[base])             * (8 - fx) * (8 - fy)
          + int'(texels[base + 1])         * fx       * (8 - fy)
          + int'(texels[base + IMG_W])     * (8 - fx) * fy
          + int'(texels[base + IMG_W + 1]) * fx       * fy;
      return 8'(sum >> 6);
    endfunction

    function void note_item(logic op, logic [15:0] addr, logic [7:0] val,
                            logic [8:0] px, logic [7:0] py,
                            logic signed [7:0] dx, logic signed [7:0] dy);
      if (op == OP_WRITE) begin
        if (addr < NTEXELS)
          texels[addr] = val;
      end else begin
        pending_pixels.push_back(warp_pixel(px, py, dx, dy));
      end
    endfunction

    function void check_pixel(logic [7:0] got);
      logic [7:0] want;
      if (pending_pixels.size() == 0) begin
        errors++;
        $error("pixel_value: expected none, actual %0d", got);
        return;
      end
      want = pending_pixels.pop_front();
      if (got !== want) begin
        errors++;
        $error("pixel_value: expected %0d, actual %0d", want, got);
      end
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction
  endclass

endpackage

### verif/tb_top.sv
// Top-level testbench for displacement_warp_bilinear: directed corner items,
// then random write/render traffic in both filter modes, checked by scoreboard.
// Depends on dwb_pkg, dwb_tb_pkg and the block's RTL.
module tb_top;
  import dwb_pkg::*;
  import dwb_tb_pkg::*;

  localparam int RUN_LIMIT    = 1_000_000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int PHASES       = 6;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic              operation_i;
  logic [15:0]       texel_address_i;
  logic [7:0]        texel_value_i;
  logic [8:0]        pixel_x_i;
  logic [7:0]        pixel_y_i;
  logic signed [7:0] disp_x_i;
  logic signed [7:0] disp_y_i;
  logic              done_o;
  logic [7:0]        pixel_value_o;
  logic              cfg_we_i;
  logic              cfg_wdata_i;

  warp_scoreboard sb;
  bit             loaded [NTEXELS];  // texels already written by stimulus
  int             items_sent;        // accepted items, ignored writes excluded
  bit             steady;            // burst stretch: no sender gaps
  int unsigned    cycles = 0;

  displacement_warp_bilinear uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .texel_address_i(texel_address_i),
    .texel_value_i  (texel_value_i),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .disp_x_i       (disp_x_i),
    .disp_y_i       (disp_y_i),
    .done_o         (done_o),
    .pixel_value_o  (pixel_value_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: generous bound on total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("** displacement_warp_bilinear: FAILED **");
      $finish;
    end
  end

  // Results cannot be held off: every done_o cycle carries one pixel.
  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_pixel(pixel_value_o);
  end

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    if (steady)
      return 0;
    r = $urandom_range(99);
    if (r < 65)
      return 0;
    if (r < 92)
      return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Present one item, hold it until accepted (start high, busy low at an edge).
  // Start stays high after acceptance; the next call lowers it only for a gap.
  task automatic send_item(logic op, logic [15:0] addr, logic [7:0] val,
                           logic [8:0] px, logic [7:0] py,
                           logic [7:0] dx, logic [7:0] dy);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    operation_i     <= op;
    texel_address_i <= addr;
    texel_value_i   <= val;
    pixel_x_i       <= px;
    pixel_y_i       <= py;
    disp_x_i        <= dx;
    disp_y_i        <= dy;
    start           <= 1'b1;
    do @(posedge clk_i); while (busy);
    sb.note_item(op, addr, val, px, py, dx, dy);
    if (op == OP_WRITE) begin
      if (addr < NTEXELS) begin
        loaded[addr] = 1'b1;
        items_sent++;
      end
    end else begin
      items_sent++;
    end
  endtask

  // Render fields are don't-care on a write; fill them with noise.
  task automatic write_texel(logic [15:0] addr, logic [7:0] val);
    send_item(OP_WRITE, addr, val, 9'($urandom), 8'($urandom),
              8'($urandom), 8'($urandom));
  endtask

  // Render one pixel. If the displaced 2x2 block is inside the image, any
  // texel of it not yet written is written first, so no read ever hits an
  // undefined location.
  task automatic render(logic [8:0] px, logic [7:0] py,
                        logic signed [7:0] dx, logic signed [7:0] dy);
    int col, row, k, a;
    col = int'(px) + int'(dx >>> 3);
    row = int'(py) + int'(dy >>> 3);
    if (col >= 0 && col < IMG_W - 1 && row >= 0 && row < IMG_H - 1) begin
      for (k = 0; k < 4; k++) begin
        a = (row + k / 2) * IMG_W + col + k % 2;
        if (!loaded[a])
          write_texel(16'(a), 8'($urandom));
      end
    end
    send_item(OP_RENDER, 16'($urandom), 8'($urandom), px, py, dx, dy);
  endtask

  // Idle the sender until all pixels are back and the block is quiet, then
  // let it stay idle a while longer (a trailing write produces no result).
  task automatic settle();
    start <= 1'b0;
    while (sb.pending() != 0 || busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Mode register write; only called while the block is idle.
  task automatic write_cfg(logic mode);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_mode(mode);
  endtask

  // Corner renders, run once per filter mode.
  task automatic directed_renders();
    render(9'd0,   8'd0,   8'h00, 8'h00);  // top-left texel, no fraction
    render(9'd16,  8'd16,  8'h80, 8'h80);  // most negative displacement lands on 0,0
    render(9'd0,   8'd0,   8'h07, 8'h07);  // full fraction on an all-255 block
    render(9'd318, 8'd198, 8'h00, 8'h00);  // last valid texel position
    render(9'd303, 8'd183, 8'h7F, 8'h7F);  // most positive displacement to last block
    render(9'd319, 8'd0,   8'h00, 8'h00);  // last column: black
    render(9'd0,   8'd199, 8'h00, 8'h00);  // last row: black
    render(9'd0,   8'd0,   8'hFF, 8'h00);  // floor of -1/8 steps left of image
    render(9'd511, 8'd255, 8'h80, 8'h80);  // position beyond the image
  endtask

  // One random step: mostly well-formed renders aimed inside the image,
  // the rest plain writes (some out of range) and unconstrained renders.
  task automatic random_step();
    int r, ix, iy, lo, hi, col, row;
    logic signed [7:0] dx, dy;
    logic [8:0] px;
    logic [7:0] py, v;
    if ($urandom_range(49) == 0)
      steady = !steady;
    r  = $urandom_range(99);
    dx = 8'($urandom);
    dy = 8'($urandom);
    if (r < 55) begin
      ix = int'(dx >>> 3);
      iy = int'(dy >>> 3);
      lo = (ix < 0) ? -ix : 0;
      hi = IMG_W - 2 - ix;
      case ($urandom_range(9))
        0:       px = 9'(lo);
        1:       px = 9'(hi);
        default: px = 9'($urandom_range(hi, lo));
      endcase
      lo = (iy < 0) ? -iy : 0;
      hi = IMG_H - 2 - iy;
      case ($urandom_range(9))
        0:       py = 8'(lo);
        1:       py = 8'(hi);
        default: py = 8'($urandom_range(hi, lo));
      endcase
      col = int'(px) + ix;
      row = int'(py) + iy;
      // sometimes refresh one tap right before the read
      if ($urandom_range(3) == 0)
        write_texel(16'((row + $urandom_range(1)) * IMG_W + col + $urandom_range(1)),
                    8'($urandom));
      render(px, py, dx, dy);
    end else if (r < 75) begin
      case ($urandom_range(7))
        0:       v = 8'h00;
        1:       v = 8'hFF;
        default: v = 8'($urandom);
      endcase
      if ($urandom_range(9) == 0)
        write_texel(16'($urandom_range(65535)), v);
      else
        write_texel(16'($urandom_range(NTEXELS - 1)), v);
    end else begin
      render(9'($urandom), 8'($urandom), dx, dy);
    end
  endtask

  initial begin
    int phase;
    sb = new();
    rst_ni          <= 1'b0;
    start           <= 1'b0;
    operation_i     <= OP_WRITE;
    texel_address_i <= '0;
    texel_value_i   <= '0;
    pixel_x_i       <= '0;
    pixel_y_i       <= '0;
    disp_x_i        <= '0;
    disp_y_i        <= '0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= 1'b0;
    steady          = 1'b0;
    items_sent      = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: corner blocks, ignored out-of-range writes, corner renders.
    write_cfg(1'b0);
    write_texel(16'd0,     8'hFF);
    write_texel(16'd1,     8'hFF);
    write_texel(16'd320,   8'hFF);
    write_texel(16'd321,   8'hFF);
    write_texel(16'd63678, 8'h80);
    write_texel(16'd63679, 8'h01);
    write_texel(16'd63998, 8'hFE);
    write_texel(16'd63999, 8'h7F);
    write_texel(16'hFFFF,  8'h5A);
    write_texel(16'd64000, 8'h00);
    directed_renders();
    settle();
    write_cfg(1'b1);
    directed_renders();
    settle();

    // Random phases, alternating filter mode; each ends with a full drain.
    items_sent = 0;
    for (phase = 0; phase < PHASES; phase++) begin
      write_cfg(logic'(phase % 2));
      while (items_sent < (phase + 1) * RANDOM_ITEMS / PHASES)
        random_step();
      settle();
    end

    if (sb.errors == 0 && sb.pending() == 0)
      $display("** displacement_warp_bilinear: PASSED **");
    else
      $display("** displacement_warp_bilinear: FAILED **");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/dwb_pkg.sv
rtl/dwb_ram.sv
rtl/dwb_ctrl.sv
rtl/dwb_dp.sv
rtl/displacement_warp_bilinear.sv
rtl/dwb_checker.sv
verif/dwb_tb_pkg.sv
verif/tb_top.sv
